// File: design/ignition_retard_burst_scheduler_core_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef IGNITION_RETARD_BURST_SCHEDULER_CORE_DEFINES_SVH
`define IGNITION_RETARD_BURST_SCHEDULER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define IRBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also holds during reset.
`define IRBS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IRBS_ASSERT(label, prop, msg)
`define IRBS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: design/irbs_pkg.sv
`timescale 1ns / 1ps

package irbs_pkg;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_BURBLE = 2'd1,
        MODE_LAUNCH = 2'd2,
        MODE_DECEL  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_ENABLE   = 3'd0,
        REG_MODE     = 3'd1,
        REG_RPM_LOW  = 3'd2,
        REG_RPM_HIGH = 3'd3,
        REG_RETARD   = 3'd4,
        REG_WINDOW   = 3'd5,
        REG_JITTER   = 3'd6
    } reg_index_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 14;

    localparam logic [13:0] RST_RPM_LOW  = 14'd3000;
    localparam logic [13:0] RST_RPM_HIGH = 14'd7000;
    localparam logic [8:0]  RST_RETARD   = 9'd150;
    localparam logic [10:0] RST_WINDOW   = 11'd200;

    // Linear congruential generator and its two-step form, x2 = A*A*x + (A*C + C).
    localparam logic [31:0] LCG_MUL  = 32'd1664525;
    localparam logic [31:0] LCG_ADD  = 32'd1013904223;
    localparam logic [31:0] LCG_SEED = 32'hC0FFEE42;
    localparam logic [63:0] LCG_MUL_SQ = 64'(LCG_MUL) * 64'(LCG_MUL);
    localparam logic [63:0] LCG_ADD_SQ = 64'(LCG_MUL) * 64'(LCG_ADD) + 64'(LCG_ADD);
    localparam logic [31:0] LCG_MUL2 = LCG_MUL_SQ[31:0];
    localparam logic [31:0] LCG_ADD2 = LCG_ADD_SQ[31:0];

    localparam logic [31:0]        SAMPLE_MS   = 32'd100;
    localparam logic signed [16:0] DROP_RPM    = 17'sd500;
    localparam logic [7:0]         BURBLE_ODDS = 8'd64;
    localparam logic [8:0]         JIT_BASE    = 9'd255;
    localparam logic [17:0]        JIT_ROUND   = 18'd255;

    // Division by 510 through a reciprocal; exact for products below 2^18.
    localparam int unsigned DIV_DEN   = 510;
    localparam int unsigned DIV_SHIFT = 27;
    localparam int unsigned DIV_K     = ((1 << DIV_SHIFT) + DIV_DEN - 1) / DIV_DEN;
    localparam int unsigned DIV_K_W   = 19;

    typedef struct packed {
        logic        enable;
        mode_t       mode;
        logic [13:0] rpm_low;
        logic [13:0] rpm_high;
        logic [8:0]  retard_tenths;
        logic [10:0] window_ms;
        logic        random_jitter;
    } cfg_t;

    typedef struct packed {
        logic [15:0] engine_rpm;
        logic [31:0] now_ms;
        logic        launch_active;
    } sample_t;

    typedef struct packed {
        logic       active;
        logic       jitter;
        logic [7:0] r;
        logic [8:0] retard;
    } decision_t;

    typedef struct packed {
        logic       active;
        logic [8:0] amount;
    } result_t;

endpackage

// File: design/irbs_if.sv
`timescale 1ns / 1ps

interface irbs_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] engine_rpm;
    logic [31:0] now_ms;
    logic        launch_active;

    modport source (output valid, output engine_rpm, output now_ms, output launch_active,
                    input ready);
    modport sink   (input valid, input engine_rpm, input now_ms, input launch_active,
                    output ready);
endinterface

interface irbs_out_if;
    logic       valid;
    logic       ready;
    logic       retard_active;
    logic [8:0] retard_out;

    modport source (output valid, output retard_active, output retard_out, input ready);
    modport sink   (input valid, input retard_active, input retard_out, output ready);
endinterface

interface irbs_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [irbs_pkg::CFG_INDEX_W-1:0]   index;
    logic [irbs_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/irbs_regs.sv
`timescale 1ns / 1ps

module irbs_regs
(
    input  logic              clk,
    input  logic              rst_n,
    irbs_cfg_if.sink          cfg,
    output irbs_pkg::cfg_t    regs,
    output logic              deadline_clr
);

    irbs_pkg::cfg_t regs_reg;
    logic           wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid;
    assign regs      = regs_reg;

    // Turning the block off or changing the mode drops any open window.
    assign deadline_clr = wr && (((cfg.index == irbs_pkg::REG_ENABLE) && !cfg.data[0])
                                 || (cfg.index == irbs_pkg::REG_MODE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.enable        <= 1'b0;
            regs_reg.mode          <= irbs_pkg::MODE_OFF;
            regs_reg.rpm_low       <= irbs_pkg::RST_RPM_LOW;
            regs_reg.rpm_high      <= irbs_pkg::RST_RPM_HIGH;
            regs_reg.retard_tenths <= irbs_pkg::RST_RETARD;
            regs_reg.window_ms     <= irbs_pkg::RST_WINDOW;
            regs_reg.random_jitter <= 1'b1;
        end
        else if (wr)
        begin
            case (cfg.index)
                irbs_pkg::REG_ENABLE:   regs_reg.enable        <= cfg.data[0];
                irbs_pkg::REG_MODE:     regs_reg.mode          <= irbs_pkg::mode_t'(cfg.data[1:0]);
                irbs_pkg::REG_RPM_LOW:  regs_reg.rpm_low       <= cfg.data[13:0];
                irbs_pkg::REG_RPM_HIGH: regs_reg.rpm_high      <= cfg.data[13:0];
                irbs_pkg::REG_RETARD:   regs_reg.retard_tenths <= cfg.data[8:0];
                irbs_pkg::REG_WINDOW:   regs_reg.window_ms     <= cfg.data[10:0];
                irbs_pkg::REG_JITTER:   regs_reg.random_jitter <= cfg.data[0];
                default:                ;
            endcase
        end
    end

endmodule

// File: design/irbs_sched.sv
`timescale 1ns / 1ps
`include "ignition_retard_burst_scheduler_core_defines.svh"

module irbs_sched
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  irbs_pkg::sample_t    item,
    input  irbs_pkg::cfg_t       regs,
    input  logic                 deadline_clr,
    output irbs_pkg::decision_t  dec
);

    logic [31:0]        lcg_reg;
    logic [31:0]        deadline_reg;
    logic [31:0]        last_time_reg;
    logic [15:0]        last_rpm_reg;
    irbs_pkg::decision_t dec_reg;

    logic [31:0]        lcg_next;
    logic [31:0]        x1;
    logic [31:0]        x2;
    logic [31:0]        dt;
    logic [31:0]        ahead_diff;
    logic [31:0]        new_deadline;
    logic signed [16:0] drop;
    logic               running;
    logic               in_band;
    logic               burble_sample;
    logic               decel_sample;
    logic               set_deadline;
    logic               ahead;
    logic               act;
    logic               jit_step;
    logic [7:0]         r;

    // One and two generator steps are evaluated side by side.
    assign x1 = lcg_reg * irbs_pkg::LCG_MUL + irbs_pkg::LCG_ADD;
    assign x2 = lcg_reg * irbs_pkg::LCG_MUL2 + irbs_pkg::LCG_ADD2;

    assign running = regs.enable && (regs.mode != irbs_pkg::MODE_OFF);
    assign in_band = (item.engine_rpm >= {2'b00, regs.rpm_low})
                  && (item.engine_rpm <= {2'b00, regs.rpm_high});
    assign dt      = item.now_ms - last_time_reg;
    assign drop    = $signed({1'b0, last_rpm_reg}) - $signed({1'b0, item.engine_rpm});

    assign burble_sample = running && (regs.mode == irbs_pkg::MODE_BURBLE) && in_band
                        && (dt >= irbs_pkg::SAMPLE_MS);
    assign decel_sample  = running && (regs.mode == irbs_pkg::MODE_DECEL) && !dt[31]
                        && (dt >= irbs_pkg::SAMPLE_MS);

    assign set_deadline = (burble_sample && (x1[31:24] < irbs_pkg::BURBLE_ODDS))
                       || (decel_sample && in_band && (drop > irbs_pkg::DROP_RPM));
    assign new_deadline = item.now_ms + {21'b0, regs.window_ms};
    assign ahead_diff   = item.now_ms - deadline_reg;

    // A window opened at this very tick lies ahead unless its length is zero.
    assign ahead = set_deadline ? (regs.window_ms != 11'd0) : ahead_diff[31];

    always_comb
    begin
        act = 1'b0;
        case (regs.mode)
            irbs_pkg::MODE_BURBLE: act = in_band && ahead;
            irbs_pkg::MODE_LAUNCH: act = in_band && item.launch_active;
            irbs_pkg::MODE_DECEL:  act = in_band && ahead;
            default:               act = 1'b0;
        endcase
        if (!regs.enable)
        begin
            act = 1'b0;
        end
    end

    assign jit_step = act && regs.random_jitter;

    always_comb
    begin
        if (burble_sample)
        begin
            lcg_next = jit_step ? x2 : x1;
            r        = x2[23:16];
        end
        else
        begin
            lcg_next = jit_step ? x1 : lcg_reg;
            r        = x1[23:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_reg       <= irbs_pkg::LCG_SEED;
            deadline_reg  <= '0;
            last_time_reg <= '0;
            last_rpm_reg  <= '0;
        end
        else
        begin
            if (fire)
            begin
                lcg_reg <= lcg_next;
                if (burble_sample || decel_sample)
                begin
                    last_time_reg <= item.now_ms;
                end
                if (decel_sample)
                begin
                    last_rpm_reg <= item.engine_rpm;
                end
                if (set_deadline)
                begin
                    deadline_reg <= new_deadline;
                end
            end
            if (deadline_clr)
            begin
                deadline_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            dec_reg.active <= act;
            dec_reg.jitter <= regs.random_jitter;
            dec_reg.r      <= r;
            dec_reg.retard <= regs.retard_tenths;
        end
    end

    assign dec = dec_reg;

    `IRBS_ASSERT(a_deadline_clear, deadline_clr |=> (deadline_reg == 32'd0),
                 "window deadline not cleared by configuration write")
    `IRBS_ASSERT(a_decel_sample, (fire && decel_sample) |=>
                 ((last_rpm_reg == $past(item.engine_rpm))
                  && (last_time_reg == $past(item.now_ms))),
                 "decel sample not recorded")

endmodule

// File: design/irbs_scale.sv
`timescale 1ns / 1ps

module irbs_scale
(
    input  logic                 clk,
    input  logic                 load,
    input  irbs_pkg::decision_t  dec,
    output irbs_pkg::result_t    res
);

    localparam int unsigned PROD_W = 18;
    localparam int unsigned QP_W   = PROD_W + irbs_pkg::DIV_K_W;

    logic              active_reg;
    logic              jitter_reg;
    logic [8:0]        retard_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [PROD_W-1:0] prod_next;
    logic [8:0]        factor;
    logic [QP_W-1:0]   qp;
    logic [8:0]        quot;

    // retard * (255 + r) + 255, rounded division by 510 follows in the next stage.
    assign factor    = irbs_pkg::JIT_BASE + {1'b0, dec.r};
    assign prod_next = PROD_W'({9'b0, dec.retard} * {9'b0, factor}) + irbs_pkg::JIT_ROUND;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            active_reg <= dec.active;
            jitter_reg <= dec.jitter;
            retard_reg <= dec.retard;
            prod_reg   <= prod_next;
        end
    end

    assign qp   = QP_W'(prod_reg) * QP_W'(irbs_pkg::DIV_K);
    assign quot = qp[irbs_pkg::DIV_SHIFT +: 9];

    assign res.active = active_reg;
    assign res.amount = !active_reg ? 9'd0 : (jitter_reg ? quot : retard_reg);

endmodule

// File: design/ignition_retard_burst_scheduler_core.sv
// Registers on a request's path: input, decision, jitter product, result.
// Throughput: one request per cycle while results are taken; the rate is set by the
// decision stage, updating generator, sample time and window deadline per request.
// Reset (rst_n low, asynchronous): configuration registers take their reset values,
// the generator is reseeded, deadline and sample history clear, and the pipeline empties.
`timescale 1ns / 1ps
`include "ignition_retard_burst_scheduler_core_defines.svh"

module ignition_retard_burst_scheduler_core
(
    input  logic         clk,
    input  logic         rst_n,
    irbs_in_if.sink      sample,
    irbs_out_if.source   result,
    irbs_cfg_if.sink     cfg
);

    // Pipeline:
    //   stage 0  input register holding the accepted request
    //   stage 1  decision register; the scheduler state is updated as a request enters it
    //   stage 2  jitter product register
    //   output   result register, with the reciprocal division in front of it
    // Each stage takes a new request when it is empty or when it passes its own on, so
    // bubbles close up and a request is taken even while a result waits to be read.

    irbs_pkg::cfg_t      regs;
    logic                deadline_clr;
    irbs_pkg::sample_t   s0_reg;
    irbs_pkg::decision_t dec;
    irbs_pkg::result_t   res;

    logic       v0_reg;
    logic       v1_reg;
    logic       v2_reg;
    logic       out_v_reg;
    logic       out_active_reg;
    logic [8:0] out_amount_reg;

    logic rdy_out;
    logic rdy2;
    logic rdy1;
    logic rdy0;
    logic take0;
    logic fire1;
    logic load2;
    logic load_out;

    assign rdy_out = !out_v_reg || result.ready;
    assign rdy2    = !v2_reg || rdy_out;
    assign rdy1    = !v1_reg || rdy2;
    assign rdy0    = !v0_reg || rdy1;

    assign take0    = sample.valid && rdy0;
    assign fire1    = v0_reg && rdy1;
    assign load2    = v1_reg && rdy2;
    assign load_out = v2_reg && rdy_out;

    assign sample.ready = rdy0;

    irbs_regs u_regs
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .regs         (regs),
        .deadline_clr (deadline_clr)
    );

    // Stage 0: the accepted request.
    always_ff @(posedge clk)
    begin
        if (take0)
        begin
            s0_reg.engine_rpm    <= sample.engine_rpm;
            s0_reg.now_ms        <= sample.now_ms;
            s0_reg.launch_active <= sample.launch_active;
        end
    end

    // Stage 1: mode logic, window bookkeeping and the random draw.
    irbs_sched u_sched
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire1),
        .item         (s0_reg),
        .regs         (regs),
        .deadline_clr (deadline_clr),
        .dec          (dec)
    );

    // Stage 2 and the division that feeds the result register.
    irbs_scale u_scale
    (
        .clk  (clk),
        .load (load2),
        .dec  (dec),
        .res  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
            begin
                v0_reg <= sample.valid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy_out)
            begin
                out_v_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_active_reg <= res.active;
            out_amount_reg <= res.amount;
        end
    end

    assign result.valid         = out_v_reg;
    assign result.retard_active = out_active_reg;
    assign result.retard_out    = out_amount_reg;

    // The input side only stalls once every stage holds a request.
    `IRBS_ASSERT(a_full_when_stalled, !sample.ready |->
                 (v0_reg && v1_reg && v2_reg && out_v_reg),
                 "input stalled while the pipeline has room")
    // An inactive result carries no retard.
    `IRBS_ASSERT(a_inactive_zero, (out_v_reg && !out_active_reg) |->
                 (out_amount_reg == 9'd0),
                 "inactive result with nonzero retard")
    // A result leaves only when it was taken.
    `IRBS_ASSERT(a_out_drop, $fell(out_v_reg) |-> $past(result.ready),
                 "result dropped without being taken")
    `IRBS_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> (!v0_reg && !v1_reg && !v2_reg && !out_v_reg),
                 "pipeline not empty in reset")

endmodule
